// File: rtl/core/aaf_pkg.sv
// Shared widths, register indexes, mode codes and reset values for the axis filter.
`default_nettype none

package aaf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BLOCK   = 64;

  // limit registers carry one extra bit so +32768 can be written
  localparam int LIM_W     = SAMPLE_BITS + 1;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;
  localparam int BAND_W    = 16;
  localparam int BS_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BAND  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_BSIZE = CFG_IDX_W'(4);

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_AVG  = 2'd3;

  localparam logic signed [LIM_W-1:0] SAMPLE_MAX = LIM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [LIM_W-1:0] SAMPLE_MIN = LIM_W'(-(1 << (SAMPLE_BITS - 1)));

  localparam logic [MODE_W-1:0]       RST_MODE  = MODE_AVG;
  localparam logic signed [LIM_W-1:0] RST_LOWER = SAMPLE_MIN;
  localparam logic signed [LIM_W-1:0] RST_UPPER = SAMPLE_MAX;
  localparam logic [BAND_W-1:0]       RST_BAND  = '0;
  localparam logic [BS_W-1:0]         RST_BSIZE = BS_W'(1);

endpackage

`default_nettype wire

// File: rtl/core/aaf_divider.sv
// Restoring serial divider: unsigned magnitude, one quotient bit per cycle, sign applied at the end.
`default_nettype none

module aaf_divider #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7,
  parameter int QUOT_W     = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     negate,
  input  wire logic [DIVIDEND_W-1:0]    dividend,
  input  wire logic [DIVISOR_W-1:0]     divisor,
  output logic                          done,
  output logic signed [QUOT_W-1:0]      quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic                  neg;

  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic [DIVISOR_W:0]    diff;

  // trial subtract of the next dividend bit
  assign trial = {rem, dvd[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIVIDEND_W - 1);
        dvd   <= dividend;
        rem   <= '0;
        dsr   <= divisor;
        neg   <= negate;
      end else if (busy) begin
        rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        dvd <= {dvd[DIVIDEND_W-2:0], fits};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // quotient bits sit in dvd once done fires
  assign quotient = neg ? QUOT_W'(-dvd) : QUOT_W'(dvd);

endmodule

`default_nettype wire

// File: rtl/core/analog_axis_filter.sv
// Top level of the analog axis filter: conditioning, block accumulator, sequencer, output register.
`default_nettype none

// Filters one signed 16-bit axis sample per transfer and gives zero or one
// filtered value. Mode off drops everything, pass-through returns the sample,
// block-last and block-average first apply the dead band (a magnitude below
// dead_band gives zero once, then drops while it stays there) and the edge
// clamps (a sample past lower_limit or upper_limit gives the saturated limit
// once, then drops while it stays past it), and then gather block_size samples
// (0 acts as 1, above MAX_BLOCK acts as MAX_BLOCK). A full block gives its last
// sample, or its sum divided by the size truncated toward zero. Any register
// write restarts the block fill but keeps the zone flags. Timing: a sample
// that closes an averaged block larger than one starts the serial divider,
// which runs one quotient bit per cycle over the accumulator width
// (SAMPLE_BITS + clog2(MAX_BLOCK), 22 bits by default), and the input stalls
// until the quotient is registered in the output register.
// Sample stall is high while the divider runs or while a finished value waits
// for the output register to drain. Configure only while idle.
module analog_axis_filter #(
  parameter int MAX_BLOCK = aaf_pkg::MAX_BLOCK
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [aaf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [aaf_pkg::CFG_W-1:0]              cfg_data,
  input  wire logic                                   sample_valid,
  output logic                                        sample_stall,
  input  wire logic signed [aaf_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output logic signed [aaf_pkg::SAMPLE_BITS-1:0]      filtered_value
);

  localparam int SB     = aaf_pkg::SAMPLE_BITS;
  localparam int LIM_W  = aaf_pkg::LIM_W;
  localparam int SUM_W  = SB + $clog2(MAX_BLOCK);
  localparam int SIZE_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK + 1) : 1;
  localparam int CMP_W  = (aaf_pkg::BS_W > SIZE_W) ? aaf_pkg::BS_W : SIZE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  function automatic logic signed [SB-1:0] sat_limit(input logic signed [LIM_W-1:0] v);
    logic signed [SB-1:0] r;
    if (v > aaf_pkg::SAMPLE_MAX) begin
      r = SB'(aaf_pkg::SAMPLE_MAX);
    end else if (v < aaf_pkg::SAMPLE_MIN) begin
      r = SB'(aaf_pkg::SAMPLE_MIN);
    end else begin
      r = SB'(v);
    end
    return r;
  endfunction

  // configuration
  logic [aaf_pkg::MODE_W-1:0]       filter_mode;
  logic signed [LIM_W-1:0]          lower_limit;
  logic signed [LIM_W-1:0]          upper_limit;
  logic [aaf_pkg::BAND_W-1:0]       dead_band;
  logic [aaf_pkg::BS_W-1:0]         block_size;

  // filter state
  logic [SIZE_W-1:0]                fill_count;
  logic signed [SUM_W-1:0]          block_sum;
  logic                             in_dead_band;
  logic                             below_lower;
  logic                             above_upper;

  state_t                           state;
  state_t                           state_next;
  logic signed [SB-1:0]             pending;

  logic                             take;
  logic                             out_free;
  logic                             cfg_hit;
  logic [CMP_W-1:0]                 bs_ext;
  logic [SIZE_W-1:0]                size_eff;

  logic signed [LIM_W-1:0]          s_ext;
  logic [LIM_W-1:0]                 mag;
  logic                             in_db;
  logic                             db_drop;
  logic signed [LIM_W-1:0]          s_db;
  logic                             is_lo;
  logic                             is_hi;
  logic                             lim_drop;
  logic signed [SB-1:0]             s_lim;
  logic signed [SUM_W-1:0]          sum_next;
  logic [SUM_W-1:0]                 sum_mag;
  logic [SIZE_W-1:0]                fill_inc;
  logic                             full;
  logic                             joins;

  logic                             emit;
  logic signed [SB-1:0]             emit_val;
  logic                             div_start;
  logic                             div_done;
  logic signed [SB-1:0]             div_q;
  logic                             load_out;
  logic signed [SB-1:0]             load_val;
  logic                             pend_we;

  assign take         = sample_valid && !sample_stall;
  assign sample_stall = (state != ST_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // any known register index restarts the block fill
  assign cfg_hit = cfg_write && (cfg_index inside {aaf_pkg::REG_MODE, aaf_pkg::REG_LOWER,
                                                   aaf_pkg::REG_UPPER, aaf_pkg::REG_BAND,
                                                   aaf_pkg::REG_BSIZE});

  // effective block size
  assign bs_ext = CMP_W'(block_size);
  always_comb begin
    if (bs_ext == '0) begin
      size_eff = SIZE_W'(1);
    end else if (bs_ext > CMP_W'(MAX_BLOCK)) begin
      size_eff = SIZE_W'(MAX_BLOCK);
    end else begin
      size_eff = SIZE_W'(bs_ext);
    end
  end

  // dead band, then edge clamps
  assign s_ext   = LIM_W'(sample);
  assign mag     = sample[SB-1] ? $unsigned(-s_ext) : $unsigned(s_ext);
  assign in_db   = mag < LIM_W'(dead_band);
  assign db_drop = in_db && in_dead_band;
  assign s_db    = in_db ? '0 : s_ext;
  assign is_lo   = s_db < lower_limit;
  assign is_hi   = s_db > upper_limit;

  always_comb begin
    if (is_lo) begin
      lim_drop = below_lower;
      s_lim    = sat_limit(lower_limit);
    end else if (is_hi) begin
      lim_drop = above_upper;
      s_lim    = sat_limit(upper_limit);
    end else begin
      lim_drop = 1'b0;
      s_lim    = $signed(s_db[SB-1:0]);
    end
  end

  // block accumulator
  assign sum_next = block_sum + SUM_W'(s_lim);
  assign sum_mag  = sum_next[SUM_W-1] ? $unsigned(-sum_next) : $unsigned(sum_next);
  assign fill_inc = fill_count + SIZE_W'(1);
  assign full     = fill_inc >= size_eff;
  assign joins    = take && !db_drop && !lim_drop &&
                    (filter_mode == aaf_pkg::MODE_LAST || filter_mode == aaf_pkg::MODE_AVG);

  always_comb begin
    emit      = 1'b0;
    emit_val  = sample;
    div_start = 1'b0;
    if (take) begin
      case (filter_mode)
        aaf_pkg::MODE_PASS: begin
          emit = 1'b1;
        end
        aaf_pkg::MODE_LAST, aaf_pkg::MODE_AVG: begin
          if (joins && full) begin
            if (filter_mode == aaf_pkg::MODE_AVG && size_eff > SIZE_W'(1)) begin
              div_start = 1'b1;
            end else begin
              emit     = 1'b1;
              emit_val = s_lim;
            end
          end
        end
        default: ;
      endcase
    end
  end

  aaf_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (SIZE_W),
    .QUOT_W     (SB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .negate   (sum_next[SUM_W-1]),
    .dividend (sum_mag),
    .divisor  (size_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    load_val   = emit_val;
    pend_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end else if (emit) begin
          if (out_free) begin
            load_out = 1'b1;
          end else begin
            pend_we    = 1'b1;
            state_next = ST_WAIT;
          end
        end
      end
      ST_DIV: begin
        load_val = div_q;
        if (div_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            pend_we    = 1'b1;
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        load_val = pending;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pending <= load_val;
    end
    if (load_out) begin
      filtered_value <= load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      filter_mode  <= aaf_pkg::RST_MODE;
      lower_limit  <= aaf_pkg::RST_LOWER;
      upper_limit  <= aaf_pkg::RST_UPPER;
      dead_band    <= aaf_pkg::RST_BAND;
      block_size   <= aaf_pkg::RST_BSIZE;
      fill_count   <= '0;
      block_sum    <= '0;
      in_dead_band <= 1'b0;
      below_lower  <= 1'b0;
      above_upper  <= 1'b0;
    end else begin
      state <= state_next;

      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // zone flags move only in the block modes
      if (take && (filter_mode == aaf_pkg::MODE_LAST || filter_mode == aaf_pkg::MODE_AVG)) begin
        in_dead_band <= in_db;
        if (!db_drop) begin
          below_lower <= is_lo;
          above_upper <= !is_lo && is_hi;
        end
      end

      // register write restarts the block fill
      if (cfg_hit) begin
        fill_count <= '0;
        block_sum  <= '0;
      end else if (joins) begin
        if (full) begin
          fill_count <= '0;
          block_sum  <= '0;
        end else begin
          fill_count <= fill_inc;
          block_sum  <= sum_next;
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          aaf_pkg::REG_MODE: begin
            filter_mode <= cfg_data[aaf_pkg::MODE_W-1:0];
          end
          aaf_pkg::REG_LOWER: begin
            lower_limit <= $signed(cfg_data[LIM_W-1:0]);
          end
          aaf_pkg::REG_UPPER: begin
            upper_limit <= $signed(cfg_data[LIM_W-1:0]);
          end
          aaf_pkg::REG_BAND: begin
            dead_band <= cfg_data[aaf_pkg::BAND_W-1:0];
          end
          aaf_pkg::REG_BSIZE: begin
            block_size <= cfg_data[aaf_pkg::BS_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // divider results only land while the sequencer waits for them
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  // an open block never reaches its size
  a_fill_below_size: assert property (@(posedge clk) disable iff (rst)
    fill_count < size_eff)
    else $error("fill count reached block size");

  // a held value only exists while the output register is occupied
  a_wait_has_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> result_valid)
    else $error("holding a value with an empty output register");

  // the edge flags below_lower and above_upper are exclusive
  a_edge_flags: assert property (@(posedge clk) disable iff (rst)
    !(below_lower && above_upper))
    else $error("both edge flags set");

  // off mode never produces a value
  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    take && filter_mode == aaf_pkg::MODE_OFF && !result_valid |=> !result_valid)
    else $error("value produced in off mode");

endmodule

`default_nettype wire
